>>> hw/rtl/aes128_decrypt_otf_key_schedule_assert.svh
// Assertion macros for the AES-128 decryption pipeline
`ifndef AES128_DECRYPT_OTF_KEY_SCHEDULE_ASSERT_SVH
`define AES128_DECRYPT_OTF_KEY_SCHEDULE_ASSERT_SVH

// Next-cycle implication under reset
`define AES_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

// Same-cycle implication under reset
`define AES_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/aes_dec_pkg.sv
`timescale 1ns / 1ps
package aes_dec_pkg;
    localparam int NumRounds = 10;
    localparam int KeyPrepStages = 10;
    localparam logic [7:0] RconLast = 8'h36;
    localparam logic [7:0] RconFirst = 8'h01;

    localparam logic [0:255][7:0] SBOX = {
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [0:255][7:0] INV_SBOX = {
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    typedef enum logic [0:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } reg_index_t;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon_down(input logic [7:0] rc);
        return rc[0] ? ({1'b0, rc[7:1]} ^ 8'h8d) : {1'b0, rc[7:1]};
    endfunction

    // 128-bit word, byte 0 at the top
    function automatic logic [7:0] byte_at(input logic [127:0] w, input int i);
        return w[127 - 8 * i -: 8];
    endfunction

    function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
        logic [7:0] b [16];
        for (int i = 0; i < 16; i++) b[i] = byte_at(k, i);
        b[0] = b[0] ^ SBOX[b[13]] ^ rc;
        b[1] = b[1] ^ SBOX[b[14]];
        b[2] = b[2] ^ SBOX[b[15]];
        b[3] = b[3] ^ SBOX[b[12]];
        for (int i = 4; i < 16; i++) b[i] = b[i] ^ b[i - 4];
        for (int i = 0; i < 16; i++) key_fwd[127 - 8 * i -: 8] = b[i];
    endfunction

    function automatic logic [127:0] key_inv(input logic [127:0] k, input logic [7:0] rc);
        logic [7:0] b [16];
        for (int i = 0; i < 16; i++) b[i] = byte_at(k, i);
        for (int i = 4; i < 16; i++) b[i] = byte_at(k, i) ^ byte_at(k, i - 4);
        b[0] = b[0] ^ SBOX[b[13]] ^ rc;
        b[1] = b[1] ^ SBOX[b[14]];
        b[2] = b[2] ^ SBOX[b[15]];
        b[3] = b[3] ^ SBOX[b[12]];
        for (int i = 0; i < 16; i++) key_inv[127 - 8 * i -: 8] = b[i];
    endfunction

    function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                inv_shift_sub[127 - 8 * (r + 4 * c) -: 8] =
                    INV_SBOX[byte_at(s, r + 4 * ((c - r + 4) % 4))];
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                a[j] = byte_at(s, 4 * c + j);
                x2[j] = xtime(a[j]);
                x4[j] = xtime(x2[j]);
                x8[j] = xtime(x4[j]);
                m9[j] = x8[j] ^ a[j];
                mb[j] = x8[j] ^ x2[j] ^ a[j];
                md[j] = x8[j] ^ x4[j] ^ a[j];
                me[j] = x8[j] ^ x4[j] ^ x2[j];
            end
            for (int j = 0; j < 4; j++)
                inv_mix[127 - 8 * (4 * c + j) -: 8] = me[j] ^ mb[(j + 1) % 4]
                    ^ md[(j + 2) % 4] ^ m9[(j + 3) % 4];
        end
    endfunction
endpackage

>>> hw/rtl/aes_dec_keyprep.sv
`timescale 1ns / 1ps
module aes_dec_keyprep (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [127:0] cipher_key,
    output logic [127:0] last_key,
    output logic         ready
);
    import aes_dec_pkg::*;

    logic [127:0] key_reg;
    logic [127:0] key_next;
    logic [127:0] seed_reg;
    logic [7:0]   rc_reg;
    logic [7:0]   rc_next;
    logic [3:0]   step_reg;
    logic [3:0]   step_next;
    logic         changed;

    // Expand forward one round per cycle; restart whenever the key changes.
    assign changed = (cipher_key != seed_reg);

    always_comb
    begin
        key_next = key_reg;
        rc_next = rc_reg;
        step_next = step_reg;
        if (changed)
        begin
            key_next = cipher_key;
            rc_next = RconFirst;
            step_next = 4'd0;
        end
        else if (step_reg != 4'(KeyPrepStages))
        begin
            key_next = key_fwd(key_reg, rc_reg);
            rc_next = xtime(rc_reg);
            step_next = step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            key_reg <= '0;
            rc_reg <= RconFirst;
            step_reg <= 4'd0;
        end
        else
        begin
            seed_reg <= cipher_key;
            key_reg <= key_next;
            rc_reg <= rc_next;
            step_reg <= step_next;
        end
    end

    assign last_key = key_reg;
    assign ready = (step_reg == 4'(KeyPrepStages)) && !changed;
endmodule

>>> hw/rtl/aes_dec_round.sv
`timescale 1ns / 1ps
module aes_dec_round #(
    parameter logic [7:0] RCON = 8'h36,
    parameter bit FIRST = 1'b0,
    parameter bit LAST = 1'b0
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [127:0] in_state,
    input  logic [127:0] in_key,
    output logic         out_valid,
    output logic [127:0] out_state,
    output logic [127:0] out_key
);
    import aes_dec_pkg::*;

    logic         valid_reg;
    logic [127:0] state_reg;
    logic [127:0] state_next;
    logic [127:0] key_reg;
    logic [127:0] key_next;

    always_comb
    begin
        if (FIRST)
        begin
            key_next = in_key;
            state_next = inv_shift_sub(in_state ^ in_key);
        end
        else
        begin
            key_next = key_inv(in_key, RCON);
            if (LAST)
                state_next = in_state ^ key_next;
            else
                state_next = inv_shift_sub(inv_mix(in_state ^ key_next));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        key_reg <= key_next;
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_key = key_reg;
endmodule

>>> hw/rtl/aes128_decrypt_otf_key_schedule.sv
`timescale 1ns / 1ps
// AES-128 decryption, one 128-bit block per cycle while busy is low, through an unrolled
// pipeline of eleven stages (initial AddRoundKey, nine full rounds, final round); each
// block appears on plaintext_* with done high once it has passed all eleven registered
// stages; the receiver cannot stall. busy is high after a key write that changes the key
// while the round-10 key is expanded one round per cycle; starts during that time are refused.
`include "aes128_decrypt_otf_key_schedule_assert.svh"
module aes128_decrypt_otf_key_schedule (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] ciphertext_high,
    input  logic [63:0] ciphertext_low,
    output logic        done,
    output logic [63:0] plaintext_high,
    output logic [63:0] plaintext_low,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import aes_dec_pkg::*;

    logic [63:0]  key_high_reg;
    logic [63:0]  key_low_reg;
    logic [127:0] last_key;
    logic         key_ready;
    logic         go;
    logic         v    [NumRounds + 2];
    logic [127:0] st   [NumRounds + 2];
    logic [127:0] rk   [NumRounds + 2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    aes_dec_keyprep u_keyprep (
        .clk        (clk),
        .rst_n      (rst_n),
        .cipher_key ({key_high_reg, key_low_reg}),
        .last_key   (last_key),
        .ready      (key_ready)
    );

    assign busy = !key_ready;
    assign go = start && !busy;
    assign v[0] = go;
    assign st[0] = {ciphertext_high, ciphertext_low};
    assign rk[0] = last_key;

    aes_dec_round #(.RCON(8'h00), .FIRST(1'b1), .LAST(1'b0)) u_round_first (
        .clk(clk), .rst_n(rst_n), .in_valid(v[0]), .in_state(st[0]), .in_key(rk[0]),
        .out_valid(v[1]), .out_state(st[1]), .out_key(rk[1])
    );

    // Round constants run 0x36 down by halving in GF(2^8).
    function automatic logic [7:0] rcon_at(input int n);
        logic [7:0] rc;
        rc = RconLast;
        for (int i = 0; i < n; i++) rc = rcon_down(rc);
        return rc;
    endfunction

    for (genvar g = 1; g <= NumRounds; g++)
    begin : g_round
        aes_dec_round #(
            .RCON(rcon_at(g - 1)), .FIRST(1'b0), .LAST(g == NumRounds)
        ) u_round (
            .clk(clk), .rst_n(rst_n), .in_valid(v[g]), .in_state(st[g]), .in_key(rk[g]),
            .out_valid(v[g + 1]), .out_state(st[g + 1]), .out_key(rk[g + 1])
        );
    end

    assign done = v[NumRounds + 1];
    assign plaintext_high = st[NumRounds + 1][127:64];
    assign plaintext_low = st[NumRounds + 1][63:0];

    `AES_ASSERT_NEXT(a_key_write_busy, clk, rst_n,
        cfg_we && (cfg_data != (cfg_index ? key_low_reg : key_high_reg)), busy)
    `AES_ASSERT_NOW(a_no_start_when_busy, clk, rst_n, busy, !go)
    `AES_ASSERT_NEXT(a_stage_advance, clk, rst_n, v[1], v[2])
endmodule
